// File: rtl/index_indirection_table_unit_macros.svh
// Assertion macros shared by the checker of the index indirection table unit.
`ifndef INDEX_INDIRECTION_TABLE_UNIT_MACROS_SVH
`define INDEX_INDIRECTION_TABLE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IIT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IIT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/iit_pkg.sv
// Package with the types and constants of the index indirection table unit.
package iit_pkg;

  localparam int SLOT_W  = 16;
  localparam int VALUE_W = 16;
  localparam int AMT_W   = 16;
  localparam int RD_W    = 16;
  localparam int CAP_W   = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_SET    = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_OFFSET = 2'd2,
    OP_SWAP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POINT,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic [1:0]                opcode;
    logic [SLOT_W-1:0]         slot;
    logic [VALUE_W-1:0]        value;
    logic [VALUE_W-1:0]        other_value;
    logic signed [AMT_W-1:0]   amount;
  } in_word_t;

  typedef struct packed {
    logic [RD_W-1:0] read_value;
    logic            out_of_range;
  } out_word_t;

  // Control handed from the sequencer to the update unit at the head of the ring.
  typedef struct packed {
    logic act;
    op_t  op;
  } head_ctl_t;

endpackage

// File: rtl/index_indirection_table_unit.sv
// Top level of the index indirection table unit: ring of cells and its sequencer.
//
// The table lives in a ring of DEPTH cells that rotates by one slot in every
// clock cycle, so each slot passes the head cell once per turn and is read
// or rewritten there by a single update unit. A command word is taken when
// start is high and busy is low. A set or lookup whose slot is at or beyond
// the capacity is answered without waiting: its result appears in the cycle
// after the command is taken and busy stays low. An in-range set or lookup
// waits until its slot reaches the head. Offset and swap run one full turn
// of the ring, touching only the slots below the smaller of the highest slot
// ever set plus one and the capacity. Every command gives one result word,
// shown for exactly one cycle with out_strobe high; the receiver cannot hold
// it off. The capacity register is written with cfg_we; the user must write
// it only while the unit is idle, as the block itself does not enforce it.
// Zero acts as one and values above DEPTH act as DEPTH. Reset clears the
// whole table at once, so no clearing pass is needed.
module index_indirection_table_unit import iit_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int INDEX_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  output logic             out_strobe,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(DEPTH + 1);
  localparam int CW    = (DW > CAP_W) ? DW : CAP_W;
  localparam int HW    = SLOT_W + 1;
  localparam int NW    = (CW > HW) ? CW : HW;
  localparam int IW    = INDEX_WIDTH;

  // Sequencer state.
  state_t state_r, state_nxt;

  // The command word is held while the ring turns towards its slot.
  in_word_t cmd_r, cmd_nxt;

  logic [CAP_W-1:0]  capacity_r;
  logic [SLOT_W-1:0] highest_r, highest_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     walk_cnt_r, walk_cnt_nxt;
  logic [NW-1:0]     walk_n_r, walk_n_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_word_t         out_word_r, out_word_nxt;

  logic [CW-1:0] cap_ext;
  logic [CW-1:0] eff_cap;
  logic [NW-1:0] cap_n;
  logic [NW-1:0] slot_n;
  logic [NW-1:0] hi_plus1;
  logic [NW-1:0] head_n;
  logic          in_oor;
  logic          head_match;
  logic          head_in_walk;

  head_ctl_t     alu_ctl;
  logic [IW-1:0] alu_out;
  logic [IW-1:0] cell_q [DEPTH];

  // The effective capacity clamps the register to the range one to DEPTH.
  always_comb begin
    cap_ext = CW'(capacity_r);
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign cap_n        = NW'(eff_cap);
  assign slot_n       = NW'(in_word.slot);
  assign in_oor       = (slot_n >= cap_n);
  assign hi_plus1     = NW'(highest_r) + NW'(1);
  assign head_n       = NW'(head_r);
  assign head_match   = (head_n == NW'(cmd_r.slot));
  assign head_in_walk = (head_n < walk_n_r);

  // The head pointer names the slot now in the first cell of the ring.
  assign head_nxt = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // Ring of cells: every cell takes its neighbor's entry, and the entry that
  // leaves the head passes the update unit on its way to the tail.
  for (genvar i = 0; i < DEPTH; i++) begin : g_ring
    if (i == DEPTH - 1) begin : g_tail
      iit_cell #(.W(IW)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .d_in  (alu_out),
        .q_out (cell_q[i])
      );
    end else begin : g_body
      iit_cell #(.W(IW)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .d_in  (cell_q[i+1]),
        .q_out (cell_q[i])
      );
    end
  end

  iit_head_alu #(.W(IW)) u_alu (
    .ctl      (alu_ctl),
    .value_i  (IW'(cmd_r.value)),
    .other_i  (IW'(cmd_r.other_value)),
    .amount_i (IW'(cmd_r.amount)),
    .data_i   (cell_q[0]),
    .data_o   (alu_out)
  );

  // Next state and outputs of the sequencer.
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    highest_nxt    = highest_r;
    walk_cnt_nxt   = walk_cnt_r;
    walk_n_nxt     = walk_n_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    alu_ctl.act    = 1'b0;
    alu_ctl.op     = op_t'(cmd_r.opcode);

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt = in_word;
          case (op_t'(in_word.opcode))
            OP_SET: begin
              // The highest slot rises even when the slot is out of range.
              if (in_word.slot > highest_r) begin
                highest_nxt = in_word.slot;
              end
              if (in_oor) begin
                out_strobe_nxt          = 1'b1;
                out_word_nxt.read_value = '0;
                out_word_nxt.out_of_range = 1'b1;
              end else begin
                state_nxt = ST_POINT;
              end
            end
            OP_LOOKUP: begin
              if (in_oor) begin
                out_strobe_nxt            = 1'b1;
                out_word_nxt.read_value   = RD_W'(eff_cap - CW'(1));
                out_word_nxt.out_of_range = 1'b1;
              end else begin
                state_nxt = ST_POINT;
              end
            end
            default: begin
              walk_n_nxt   = (hi_plus1 < cap_n) ? hi_plus1 : cap_n;
              walk_cnt_nxt = AW'(DEPTH - 1);
              state_nxt    = ST_WALK;
            end
          endcase
        end
      end
      ST_POINT: begin
        if (head_match) begin
          alu_ctl.act               = (op_t'(cmd_r.opcode) == OP_SET);
          out_strobe_nxt            = 1'b1;
          out_word_nxt.out_of_range = 1'b0;
          out_word_nxt.read_value   = (op_t'(cmd_r.opcode) == OP_LOOKUP) ?
                                      RD_W'(cell_q[0]) : '0;
          state_nxt                 = ST_IDLE;
        end
      end
      ST_WALK: begin
        // One full turn visits every slot once; only the walked range changes.
        alu_ctl.act = head_in_walk;
        if (walk_cnt_r == '0) begin
          out_strobe_nxt            = 1'b1;
          out_word_nxt.read_value   = '0;
          out_word_nxt.out_of_range = 1'b0;
          state_nxt                 = ST_IDLE;
        end else begin
          walk_cnt_nxt = walk_cnt_r - AW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      capacity_r   <= CAP_RESET;
      highest_r    <= '0;
      head_r       <= '0;
      walk_cnt_r   <= '0;
      walk_n_r     <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      highest_r    <= highest_nxt;
      head_r       <= head_nxt;
      walk_cnt_r   <= walk_cnt_nxt;
      walk_n_r     <= walk_n_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// File: rtl/iit_cell.sv
// One storage cell of the rotating table ring.
module iit_cell import iit_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [W-1:0] d_in,
  output logic [W-1:0] q_out
);

  logic [W-1:0] data_r;

  // The ring rotates in every cycle; reset clears the table entry.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= d_in;
    end
  end

  assign q_out = data_r;

endmodule

// File: rtl/iit_head_alu.sv
// Update unit that rewrites the entry leaving the head cell of the ring.
module iit_head_alu import iit_pkg::*; #(
  parameter int W = 16
) (
  input  head_ctl_t    ctl,
  input  logic [W-1:0] value_i,
  input  logic [W-1:0] other_i,
  input  logic [W-1:0] amount_i,
  input  logic [W-1:0] data_i,
  output logic [W-1:0] data_o
);

  always_comb begin
    data_o = data_i;
    if (ctl.act) begin
      case (ctl.op)
        OP_SET: begin
          data_o = value_i;
        end
        OP_OFFSET: begin
          if (data_i > value_i) begin
            data_o = data_i + amount_i;
          end
        end
        OP_SWAP: begin
          if (data_i == value_i) begin
            data_o = other_i;
          end else if (data_i == other_i) begin
            data_o = value_i;
          end
        end
        default: begin
          data_o = data_i;
        end
      endcase
    end
  end

endmodule

// File: rtl/iit_checker.sv
// Port-level checker of the index indirection table unit and its bind.
`include "index_indirection_table_unit_macros.svh"

module iit_checker import iit_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_strobe,
  input out_word_t        out_word
);

  logic taken;
  logic oor_word;

  assign taken    = start && !busy;
  assign oor_word = out_strobe && out_word.out_of_range;

  `IIT_ASSERT_NEXT(a_taken_answers, taken, out_strobe || busy, "command word lost")
  `IIT_ASSERT_NOW(a_no_stray_word, out_strobe, $past(taken) || $past(busy), "stray result word")
  `IIT_ASSERT_NOW(a_done_answers, $fell(busy), out_strobe, "no result word at finish")
  `IIT_ASSERT_NOW(a_oor_immediate, oor_word, !busy && !$past(busy), "late out-of-range word")

endmodule

bind index_indirection_table_unit iit_checker u_iit_checker (.*);
